@@ rtl/e2r_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the Euler-angle to rotation-matrix block.
// CORDIC formats, angle constants and the arc tangent table. No dependencies.
package e2r_pkg;

    // Parameter defaults
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int COEF_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC datapath width (Q2.30 plus headroom) and trig output width
    localparam int CORDIC_W = 34;
    localparam int TRIG_W   = 32;

    // Angle constants in Q2.30
    localparam logic signed [CORDIC_W-1:0] Q30_PI          = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] Q30_HALF_PI     = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

@@ rtl/e2r_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: three angles in, nine matrix entries out.
// Widths follow the block parameters; no package dependency.
interface e2r_in_if #(parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;

    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_out_if #(parameter int COEF_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] r00;
    logic signed [COEF_BITS-1:0] r10;
    logic signed [COEF_BITS-1:0] r20;
    logic signed [COEF_BITS-1:0] r01;
    logic signed [COEF_BITS-1:0] r11;
    logic signed [COEF_BITS-1:0] r21;
    logic signed [COEF_BITS-1:0] r02;
    logic signed [COEF_BITS-1:0] r12;
    logic signed [COEF_BITS-1:0] r22;

    modport source (output valid, r00, r10, r20, r01, r11, r21, r02, r12, r22,
                    input ready);
    modport sink   (input valid, r00, r10, r20, r01, r11, r21, r02, r12, r22,
                    output ready);
endinterface

@@ rtl/e2r_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one angle in, cosine and sine out (Q2.30).
// Depends on e2r_pkg. Stage enables come from the owner's valid chain.
module e2r_cordic #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
    parameter int STAGES     = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic [STAGES+1:0]                 en,
    input  logic signed [ANGLE_BITS-1:0]      angle,
    output logic signed [e2r_pkg::TRIG_W-1:0] cos_val,
    output logic signed [e2r_pkg::TRIG_W-1:0] sin_val
);
    import e2r_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [STAGES+1];
    logic signed [CORDIC_W-1:0] y_reg [STAGES+1];
    logic signed [CORDIC_W-1:0] z_reg [STAGES+1];
    logic                       flip_reg [STAGES+1];

    logic signed [CORDIC_W-1:0] z_in;
    logic signed [CORDIC_W-1:0] z0_next;
    logic                       flip0_next;
    logic signed [TRIG_W-1:0]   cos_reg, sin_reg;
    logic signed [CORDIC_W-1:0] cos_next, sin_next;

    // Entry: Q3.x to Q2.30, fold into [-pi/2, pi/2]
    always_comb
    begin
        z_in       = CORDIC_W'(angle) <<< (33 - ANGLE_BITS);
        z0_next    = z_in;
        flip0_next = 1'b0;
        if (z_in > Q30_HALF_PI)
        begin
            z0_next    = z_in - Q30_PI;
            flip0_next = 1'b1;
        end
        else if (z_in < -Q30_HALF_PI)
        begin
            z0_next    = z_in + Q30_PI;
            flip0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            flip_reg[0] <= flip0_next;
        end
    end

    // Micro-rotation stages, one per register
    for (genvar k = 1; k <= STAGES; k++)
    begin : g_stage
        localparam logic signed [CORDIC_W-1:0] ATAN_K = CORDIC_W'(ATAN_Q30[k-1]);
        logic signed [CORDIC_W-1:0] dx, dy, x_next, y_next, z_next;

        always_comb
        begin
            dx = y_reg[k-1] >>> (k - 1);
            dy = x_reg[k-1] >>> (k - 1);
            if (!z_reg[k-1][CORDIC_W-1])
            begin
                x_next = x_reg[k-1] - dx;
                y_next = y_reg[k-1] + dy;
                z_next = z_reg[k-1] - ATAN_K;
            end
            else
            begin
                x_next = x_reg[k-1] + dx;
                y_next = y_reg[k-1] - dy;
                z_next = z_reg[k-1] + ATAN_K;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                flip_reg[k] <= flip_reg[k-1];
            end
        end
    end

    // Undo the fold by negating both results
    always_comb
    begin
        cos_next = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        sin_next = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en[STAGES+1])
        begin
            cos_reg <= cos_next[TRIG_W-1:0];
            sin_reg <= sin_next[TRIG_W-1:0];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ rtl/euler_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// Registers from input beat to output beat: the CORDIC stage chain plus five
// multiply/round/sum stages. Throughput: one beat per cycle while the output is
// not stalled; each pipeline stage holds its beat only while the stage after it is
// full, so bubbles are squeezed out under back-pressure.
// Reset (rst_n, async, active low) clears the stage valid bits only.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
    parameter int COEF_BITS     = e2r_pkg::COEF_BITS_DEF,
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    e2r_in_if.sink    angles,
    e2r_out_if.source matrix
);
    import e2r_pkg::*;

    localparam int C  = CORDIC_STAGES + 2;   // CORDIC register stages
    localparam int T  = C + 5;               // total register stages
    localparam int PW = 2 * TRIG_W;          // product width (Q4.60)
    localparam int SW = PW + 1;              // sum width
    localparam int SH = 62 - COEF_BITS;
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (SH - 1);
    localparam logic signed [SW-1:0] LIM      = SW'(1) <<< (COEF_BITS - 2);
    localparam logic signed [COEF_BITS-1:0] COEF_LIM = LIM[COEF_BITS-1:0];
    localparam logic signed [PW-1:0] Q30_RND  = PW'(1) <<< 29;

    logic [T-1:0] valid_reg;
    logic [T-1:0] en;

    logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;

    // Stage C: partial products
    logic signed [PW-1:0]     sxsy_raw_reg, cxsy_raw_reg;
    logic signed [TRIG_W-1:0] t1_reg [6];
    // Stage C+1: rounded partial products
    logic signed [TRIG_W-1:0] sxsy_reg, cxsy_reg;
    logic signed [TRIG_W-1:0] t2_reg [6];
    logic signed [PW-1:0]     sxsy_next, cxsy_next;
    // Stage C+2: products
    logic signed [PW-1:0]     p_reg [13];
    // Stage C+3: sums
    logic signed [SW-1:0]     sum_reg [9];
    // Stage C+4: output entries
    logic signed [COEF_BITS-1:0] r_reg [9];
    logic signed [COEF_BITS-1:0] r_next [9];

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[T-1] = !valid_reg[T-1] || matrix.ready;
        for (int k = T - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign angles.ready = en[0];
    assign matrix.valid = valid_reg[T-1];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= angles.valid;
            for (int k = 1; k < T; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // Cosine and sine of each angle
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_cordic_x (
        .clk(clk), .en(en[C-1:0]), .angle(angles.angle_x), .cos_val(cx), .sin_val(sx));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_cordic_y (
        .clk(clk), .en(en[C-1:0]), .angle(angles.angle_y), .cos_val(cy), .sin_val(sy));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_cordic_z (
        .clk(clk), .en(en[C-1:0]), .angle(angles.angle_z), .cos_val(cz), .sin_val(sz));

    // Stage C: sx*sy and cx*sy
    always_ff @(posedge clk)
    begin
        if (en[C])
        begin
            sxsy_raw_reg <= sx * sy;
            cxsy_raw_reg <= cx * sy;
            t1_reg[0] <= cx;
            t1_reg[1] <= sx;
            t1_reg[2] <= cy;
            t1_reg[3] <= sy;
            t1_reg[4] <= cz;
            t1_reg[5] <= sz;
        end
    end

    // Stage C+1: round partial products back to Q2.30, half up
    always_comb
    begin
        sxsy_next = (sxsy_raw_reg + Q30_RND) >>> 30;
        cxsy_next = (cxsy_raw_reg + Q30_RND) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (en[C+1])
        begin
            sxsy_reg <= sxsy_next[TRIG_W-1:0];
            cxsy_reg <= cxsy_next[TRIG_W-1:0];
            for (int i = 0; i < 6; i++)
                t2_reg[i] <= t1_reg[i];
        end
    end

    // Stage C+2: products in Q4.60 (t2: cx sx cy sy cz sz)
    always_ff @(posedge clk)
    begin
        if (en[C+2])
        begin
            p_reg[0]  <= t2_reg[2] * t2_reg[4];      // cy*cz
            p_reg[1]  <= sxsy_reg * t2_reg[4];       // sxsy*cz
            p_reg[2]  <= t2_reg[0] * t2_reg[5];      // cx*sz
            p_reg[3]  <= cxsy_reg * t2_reg[4];       // cxsy*cz
            p_reg[4]  <= t2_reg[1] * t2_reg[5];      // sx*sz
            p_reg[5]  <= t2_reg[2] * t2_reg[5];      // cy*sz
            p_reg[6]  <= sxsy_reg * t2_reg[5];       // sxsy*sz
            p_reg[7]  <= t2_reg[0] * t2_reg[4];      // cx*cz
            p_reg[8]  <= cxsy_reg * t2_reg[5];       // cxsy*sz
            p_reg[9]  <= t2_reg[1] * t2_reg[4];      // sx*cz
            p_reg[10] <= PW'(t2_reg[3]) <<< 30;      // sy scaled
            p_reg[11] <= t2_reg[1] * t2_reg[2];      // sx*cy
            p_reg[12] <= t2_reg[0] * t2_reg[2];      // cx*cy
        end
    end

    // Stage C+3: combine into the nine entries
    always_ff @(posedge clk)
    begin
        if (en[C+3])
        begin
            sum_reg[0] <= SW'(p_reg[0]);
            sum_reg[1] <= SW'(p_reg[2]) - SW'(p_reg[1]);
            sum_reg[2] <= SW'(p_reg[3]) + SW'(p_reg[4]);
            sum_reg[3] <= -SW'(p_reg[5]);
            sum_reg[4] <= SW'(p_reg[6]) + SW'(p_reg[7]);
            sum_reg[5] <= SW'(p_reg[9]) - SW'(p_reg[8]);
            sum_reg[6] <= -SW'(p_reg[10]);
            sum_reg[7] <= -SW'(p_reg[11]);
            sum_reg[8] <= SW'(p_reg[12]);
        end
    end

    // Stage C+4: round half up to Q2.x and clamp to plus or minus one
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            logic signed [SW-1:0] rnd;
            rnd = (sum_reg[i] + RND_HALF) >>> SH;
            if (rnd > LIM)
                rnd = LIM;
            else if (rnd < -LIM)
                rnd = -LIM;
            r_next[i] = rnd[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[C+4])
            for (int i = 0; i < 9; i++)
                r_reg[i] <= r_next[i];
    end

    assign matrix.r00 = r_reg[0];
    assign matrix.r10 = r_reg[1];
    assign matrix.r20 = r_reg[2];
    assign matrix.r01 = r_reg[3];
    assign matrix.r11 = r_reg[4];
    assign matrix.r21 = r_reg[5];
    assign matrix.r02 = r_reg[6];
    assign matrix.r12 = r_reg[7];
    assign matrix.r22 = r_reg[8];

    // An empty output stage means the pipeline can always take a beat
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[T-1] |-> angles.ready)
        else $error("input stalled with empty output stage");

    // Input back-pressure only arises from a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !angles.ready |-> (valid_reg[T-1] && !matrix.ready))
        else $error("input stalled without output stall");

    // Diagonal entries r00 and r22 stay within plus or minus one
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[T-1] |-> (r_reg[0] <= COEF_LIM && r_reg[0] >= -COEF_LIM
            && r_reg[8] <= COEF_LIM && r_reg[8] >= -COEF_LIM))
        else $error("diagonal entry out of range");

    // The y-angle CORDIC results stay near unit magnitude
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[C-1] |-> (cy <= 32'sd1073807360 && cy >= -32'sd1073807360
            && sy <= 32'sd1073807360 && sy >= -32'sd1073807360))
        else $error("CORDIC output out of range");

endmodule

@@ dv/euler_to_rotation_matrix_tb.sv @@
`timescale 1ns / 1ps
// Testbench for euler_to_rotation_matrix: directed angle table then random beats,
// every output beat checked against a bit-exact CORDIC matrix predictor.
// Depends on rtl/e2r_pkg.sv, rtl/e2r_if.sv and rtl/euler_to_rotation_matrix.sv.
module euler_to_rotation_matrix_tb;
    import e2r_pkg::*;

    localparam int AB         = 16;
    localparam int CB         = 16;
    localparam int STAGES     = 16;
    localparam int N_RANDOM   = 1030;
    localparam int IDLE_LIMIT = 5000;
    localparam int HALF_PI_Q13 = 12868;

    typedef logic [8:0][CB-1:0] coefs_t;
    typedef struct {
        logic [AB-1:0] ax;
        logic [AB-1:0] ay;
        logic [AB-1:0] az;
    } angles_t;

    logic clk;
    logic rst_n;

    e2r_in_if  #(.ANGLE_BITS(AB)) angles_if ();
    e2r_out_if #(.COEF_BITS(CB))  matrix_if ();

    euler_to_rotation_matrix #(
        .ANGLE_BITS    (AB),
        .COEF_BITS     (CB),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles_if),
        .matrix (matrix_if)
    );

    coefs_t matrix_q[$];
    int     errors;
    int     idle_cycles;
    bit     hold_off_req;
    bit     no_idle;

    string entry_name[9] = '{"r00", "r10", "r20", "r01", "r11", "r21", "r02", "r12",
                             "r22"};

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        angles_if.valid   = 1'b0;
        angles_if.angle_x = '0;
        angles_if.angle_y = '0;
        angles_if.angle_z = '0;
        matrix_if.ready   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
    end

    // Cosine and sine of one Q2.30 angle, half-pi folding then CORDIC
    function automatic void cordic_trig(input longint ang, output longint c,
                                        output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = CORDIC_GAIN_INV;
        y = 0;
        z = ang;
        flip = 1'b0;
        if (z > Q30_HALF_PI)
        begin
            z = z - Q30_PI;
            flip = 1'b1;
        end
        else if (z < -longint'(Q30_HALF_PI))
        begin
            z = z + Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_Q30[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Q4.60 sum to rounded, saturated Q2.14
    function automatic logic [CB-1:0] round_coef(input longint v);
        longint r;
        longint lim;
        lim = longint'(1) <<< (CB - 2);
        r = (v + (longint'(1) <<< (61 - CB))) >>> (62 - CB);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[CB-1:0];
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic coefs_t rotation_matrix(input logic [AB-1:0] ax,
                                               input logic [AB-1:0] ay,
                                               input logic [AB-1:0] az);
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        coefs_t m;
        cordic_trig(longint'($signed(ax)) <<< (33 - AB), cx, sx);
        cordic_trig(longint'($signed(ay)) <<< (33 - AB), cy, sy);
        cordic_trig(longint'($signed(az)) <<< (33 - AB), cz, sz);
        sxsy = q30_product(sx, sy);
        cxsy = q30_product(cx, sy);
        m[0] = round_coef(cy * cz);
        m[1] = round_coef(-(sxsy * cz) + cx * sz);
        m[2] = round_coef(cxsy * cz + sx * sz);
        m[3] = round_coef(-(cy * sz));
        m[4] = round_coef(sxsy * sz + cx * cz);
        m[5] = round_coef(-(cxsy * sz) + sx * cz);
        m[6] = round_coef(-(sy * (longint'(1) <<< 30)));
        m[7] = round_coef(-(sx * cy));
        m[8] = round_coef(cx * cy);
        return m;
    endfunction

    task automatic report_mismatch(input string entry, input logic [CB-1:0] got,
                                   input logic [CB-1:0] want);
        $display("%0t mismatch %s: got %0d, want %0d", $time, entry, $signed(got),
                 $signed(want));
        errors++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Monitor: both handshakes sampled at the rising edge, plus watchdog
    always @(posedge clk)
    begin
        coefs_t want, got;
        if (rst_n)
        begin
            idle_cycles++;
            if (angles_if.valid && angles_if.ready)
            begin
                idle_cycles = 0;
                matrix_q.insert(matrix_q.size(),
                                rotation_matrix(angles_if.angle_x,
                                                angles_if.angle_y,
                                                angles_if.angle_z));
            end
            if (matrix_if.valid && matrix_if.ready)
            begin
                idle_cycles = 0;
                got = {matrix_if.r22, matrix_if.r12, matrix_if.r02,
                       matrix_if.r21, matrix_if.r11, matrix_if.r01,
                       matrix_if.r20, matrix_if.r10, matrix_if.r00};
                if (matrix_q.size() == 0)
                begin
                    $display("%0t output beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = matrix_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want[i])
                            report_mismatch(entry_name[i], got[i], want[i]);
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                matrix_if.ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                matrix_if.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                matrix_if.ready = 1'b1;
        end
    end

    // One input beat after a random gap; returns just after acceptance
    task automatic send_angles(input logic [AB-1:0] ax, input logic [AB-1:0] ay,
                               input logic [AB-1:0] az);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            angles_if.valid = 1'b0;
        end
        @(negedge clk);
        angles_if.valid   = 1'b1;
        angles_if.angle_x = ax;
        angles_if.angle_y = ay;
        angles_if.angle_z = az;
        do
            @(posedge clk);
        while (!angles_if.ready);
    endtask

    // Random angle: mostly full range, some near the folding points
    function automatic logic [AB-1:0] pick_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return AB'($urandom);
        if (r < 9)
            return AB'(($urandom_range(0, 1) ? HALF_PI_Q13 : -HALF_PI_Q13)
                       + $signed($urandom_range(0, 4)) - 2);
        return AB'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    endfunction

    // Directed angles: zero, extremes, around half pi, pi, small values
    angles_t directed[] = '{
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'h7fff, 16'h7fff, 16'h7fff},
        '{16'h8000, 16'h8000, 16'h8000},
        '{16'h7fff, 16'h8000, 16'h0000},
        '{16'sd12868, 16'sd0, 16'sd0},
        '{16'sd12869, 16'sd12869, 16'sd12869},
        '{-16'sd12868, -16'sd12868, -16'sd12868},
        '{-16'sd12869, -16'sd12869, -16'sd12869},
        '{16'sd0, 16'sd12868, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd12868},
        '{16'sd25736, -16'sd25736, 16'sd25736},
        '{16'hffff, 16'h0001, 16'hffff},
        '{16'h0001, 16'hffff, 16'h0001},
        '{16'h5555, 16'haaaa, 16'h5555},
        '{16'haaaa, 16'h5555, 16'haaaa},
        '{16'sd6434, 16'sd4289, -16'sd8579},
        '{16'sd8192, -16'sd8192, 16'sd16384}
    };

    // Stimulus
    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_off_req = 1'b0;
        no_idle = 1'b0;
        @(posedge rst_n);
        foreach (directed[i])
            send_angles(directed[i].ax, directed[i].ay, directed[i].az);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 200 == 100)
                no_idle = ~no_idle;
            if (n == 300)
                hold_off_req = 1'b1;
            if (n == 600)
            begin
                @(negedge clk);
                angles_if.valid = 1'b0;
                wait (matrix_q.size() == 0);
            end
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        @(negedge clk);
        angles_if.valid = 1'b0;
        wait (matrix_q.size() == 0);
        repeat (STAGES + 20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/e2r_pkg.sv
rtl/e2r_if.sv
rtl/e2r_cordic.sv
rtl/euler_to_rotation_matrix.sv
dv/euler_to_rotation_matrix_tb.sv
